### hw/rtl/trpt_pkg.sv
// Shared types, codes and constants of the triggered reward and pulse train timer.
// No dependencies; used by trpt_step and the top level.
package trpt_pkg;

  localparam int unsigned MAX_EV = 5;
  localparam int unsigned EV_IDX_W = $clog2(MAX_EV);
  localparam logic ARM_LINE_USED = 1'b1;
  localparam int unsigned CFG_ADDR_W = 5;

  typedef enum logic [2:0] {
    EV_NONE        = 3'd0,
    EV_REWARD_IN   = 3'd1,
    EV_UNREWARD_IN = 3'd2,
    EV_NOSE_OUT    = 3'd3,
    EV_STIM_START  = 3'd4,
    EV_STIM_END    = 3'd5,
    EV_TIMEOUT     = 3'd6,
    EV_MANUAL      = 3'd7
  } ev_t;

  localparam logic [1:0] END_TIME     = 2'd0;
  localparam logic [1:0] END_NOSE_OUT = 2'd1;
  localparam logic [1:0] END_NOSE_IN  = 2'd2;
  localparam logic [1:0] END_UNUSED   = 2'd3;

  localparam logic [2:0] REG_REWARD_TIME  = 3'd0;
  localparam logic [2:0] REG_SINGLE_SHOT  = 3'd1;
  localparam logic [2:0] REG_LASER_ENABLE = 3'd2;
  localparam logic [2:0] REG_END_MODE     = 3'd3;
  localparam logic [2:0] REG_STIM_DELAY   = 3'd4;
  localparam logic [2:0] REG_STIM_LENGTH  = 3'd5;
  localparam logic [2:0] REG_PULSE_WIDTH  = 3'd6;
  localparam logic [2:0] REG_PULSE_PERIOD = 3'd7;

  typedef struct packed {
    logic [31:0] now_us;
    logic        beam_level;
    logic        arm_pin_level;
    logic        arm_write;
    logic        arm_value;
    logic        reward_now;
    logic        other_nose_in;
  } in_item_t;

  typedef struct packed {
    logic [2:0] event_res;
    logic       solenoid;
    logic       laser;
    logic       nose_in_seen;
    logic       last;
  } out_item_t;

  typedef struct packed {
    logic [31:0] reward_time;
    logic        single_shot;
    logic        laser_enable;
    logic [1:0]  end_mode;
    logic [31:0] stim_delay;
    logic [31:0] stim_length;
    logic [31:0] pulse_width;
    logic [31:0] pulse_period;
  } cfg_t;

  typedef struct packed {
    logic        nose_present;
    logic        armed;
    logic        arm_line_last;
    logic        rewarding;
    logic [31:0] reward_start;
    logic        stim_active;
    logic [31:0] stim_start;
    logic        laser_lit;
    logic [31:0] next_pulse_at;
  } state_t;

  typedef struct packed {
    logic [MAX_EV-1:0][2:0] ev;
    logic [EV_IDX_W:0]      count;
    logic                   seen;
  } step_res_t;

  function automatic step_res_t push_ev(step_res_t r, ev_t e);
    step_res_t q;
    q = r;
    if (r.count < (EV_IDX_W+1)'(MAX_EV)) begin
      q.ev[r.count[EV_IDX_W-1:0]] = e;
      q.count = r.count + (EV_IDX_W+1)'(1);
    end
    return q;
  endfunction

endpackage

### hw/rtl/trpt_step.sv
// One update of the port controller: arm, reward, stimulus and pulse timers.
// Pure combinational; depends on trpt_pkg for the state, config and event types.
module trpt_step
  import trpt_pkg::*;
(
  input  cfg_t      cfg,
  input  state_t    st,
  input  in_item_t  item,
  output state_t    st_nxt,
  output step_res_t res
);

  state_t      s;
  step_res_t   r;
  logic [31:0] t_stim;
  logic [31:0] t_pulse;
  logic [31:0] pulse_off_at;
  logic [31:0] npa_adv;

  always_comb begin
    s = st;
    r = '0;

    if (item.arm_write) begin
      s.armed = item.arm_value;
    end

    if (item.reward_now && (cfg.reward_time != 32'd0)) begin
      s.rewarding = 1'b1;
      s.reward_start = item.now_us;
      r = push_ev(r, EV_MANUAL);
    end

    if (item.other_nose_in && s.stim_active && (cfg.end_mode == END_NOSE_IN)) begin
      s.stim_active = 1'b0;
      s.laser_lit = 1'b0;
      r = push_ev(r, EV_STIM_END);
    end

    if (ARM_LINE_USED && (item.arm_pin_level != s.arm_line_last)) begin
      s.arm_line_last = item.arm_pin_level;
      s.armed = item.arm_pin_level;
    end

    if (item.beam_level != s.nose_present) begin
      if (item.beam_level) begin
        s.nose_present = 1'b1;
        r.seen = 1'b1;
        if (s.armed && (cfg.reward_time != 32'd0)) begin
          s.rewarding = 1'b1;
          s.reward_start = item.now_us;
          r = push_ev(r, EV_REWARD_IN);
        end else begin
          r = push_ev(r, EV_UNREWARD_IN);
        end
        if (cfg.single_shot) begin
          s.armed = 1'b0;
        end
        if (s.stim_active && (cfg.end_mode == END_NOSE_IN)) begin
          s.stim_active = 1'b0;
          s.laser_lit = 1'b0;
          r = push_ev(r, EV_STIM_END);
        end
        if (cfg.laser_enable) begin
          s.stim_active = 1'b1;
          s.stim_start = item.now_us;
          s.next_pulse_at = 32'd0;
          r = push_ev(r, EV_STIM_START);
        end
      end else begin
        s.nose_present = 1'b0;
        r = push_ev(r, EV_NOSE_OUT);
        if (s.stim_active && (cfg.end_mode == END_NOSE_OUT)) begin
          s.stim_active = 1'b0;
          s.laser_lit = 1'b0;
          r = push_ev(r, EV_STIM_END);
        end
      end
    end

    if (s.rewarding && ((item.now_us - s.reward_start) > cfg.reward_time)) begin
      s.rewarding = 1'b0;
    end

    t_stim = item.now_us - s.stim_start;
    t_pulse = t_stim - cfg.stim_delay;
    pulse_off_at = s.next_pulse_at + cfg.pulse_width;
    npa_adv = s.next_pulse_at + cfg.pulse_period;

    if (s.stim_active && (t_stim > cfg.stim_delay)) begin
      if (t_pulse >= cfg.stim_length) begin
        s.stim_active = 1'b0;
        s.laser_lit = 1'b0;
        r = push_ev(r, EV_STIM_END);
        if (cfg.end_mode != END_TIME) begin
          r = push_ev(r, EV_TIMEOUT);
        end
      end else if ((t_pulse >= s.next_pulse_at) && !s.laser_lit) begin
        s.laser_lit = 1'b1;
      end else if ((t_pulse >= pulse_off_at) && s.laser_lit) begin
        s.next_pulse_at = npa_adv;
        if (t_pulse < npa_adv) begin
          s.laser_lit = 1'b0;
        end
      end
    end

    if (r.count == '0) begin
      r = push_ev(r, EV_NONE);
    end

    st_nxt = s;
    res = r;
  end

endmodule

### hw/rtl/triggered_reward_and_pulse_train_timer_top.sv
// Top level of the triggered reward and pulse train timer: config registers,
// input register, step logic and result buffer. Depends on trpt_pkg and trpt_step.
//
// An update is taken into an input register, applied to the port state by the step
// logic, and its event records (one to five) are loaded into a result buffer that
// hands out one record per cycle while out_ready is high. The first record of an
// update is offered once it has passed the input register and been loaded into the
// result buffer, which takes it only when free. An update with one record frees
// the buffer as that record is taken, so such updates can follow every cycle while
// out_ready is high; an update with more records holds the buffer until its last
// record is taken. Registers sit at byte addresses 4*i; pready is tied high.
module triggered_reward_and_pulse_train_timer_top
  import trpt_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  in_item_t              in_data,
  output logic                  out_valid,
  input  logic                  out_ready,
  output out_item_t             out_data,
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic [CFG_ADDR_W-1:0] paddr,
  input  logic [31:0]           pwdata,
  output logic [31:0]           prdata,
  output logic                  pready
);

  cfg_t        cfg_r;
  state_t      state_r;
  state_t      state_nxt;
  step_res_t   step_res;
  in_item_t    in_item_r;
  logic        in_vld_r;
  logic        res_vld_r;
  logic [MAX_EV-1:0][2:0] res_ev_r;
  logic [EV_IDX_W-1:0]    res_idx_r;
  logic [EV_IDX_W-1:0]    res_last_r;
  logic        res_sol_r;
  logic        res_las_r;
  logic        res_seen_r;
  logic        res_is_last;
  logic        res_free;
  logic        advance;
  logic        out_xfer;
  logic        cfg_wr;
  logic [2:0]  reg_sel;

  assign pready = 1'b1;
  assign reg_sel = paddr[4:2];
  assign cfg_wr = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r <= '0;
    end else if (cfg_wr) begin
      unique case (reg_sel)
        REG_REWARD_TIME:  cfg_r.reward_time <= pwdata;
        REG_SINGLE_SHOT:  cfg_r.single_shot <= pwdata[0];
        REG_LASER_ENABLE: cfg_r.laser_enable <= pwdata[0];
        REG_END_MODE: begin
          if (pwdata[1:0] != END_UNUSED) begin
            cfg_r.end_mode <= pwdata[1:0];
          end
        end
        REG_STIM_DELAY:   cfg_r.stim_delay <= pwdata;
        REG_STIM_LENGTH:  cfg_r.stim_length <= pwdata;
        REG_PULSE_WIDTH:  cfg_r.pulse_width <= pwdata;
        REG_PULSE_PERIOD: cfg_r.pulse_period <= pwdata;
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (reg_sel)
      REG_REWARD_TIME:  prdata = cfg_r.reward_time;
      REG_SINGLE_SHOT:  prdata = {31'd0, cfg_r.single_shot};
      REG_LASER_ENABLE: prdata = {31'd0, cfg_r.laser_enable};
      REG_END_MODE:     prdata = {30'd0, cfg_r.end_mode};
      REG_STIM_DELAY:   prdata = cfg_r.stim_delay;
      REG_STIM_LENGTH:  prdata = cfg_r.stim_length;
      REG_PULSE_WIDTH:  prdata = cfg_r.pulse_width;
      REG_PULSE_PERIOD: prdata = cfg_r.pulse_period;
      default:          prdata = 32'd0;
    endcase
  end

  trpt_step u_step (
    .cfg    (cfg_r),
    .st     (state_r),
    .item   (in_item_r),
    .st_nxt (state_nxt),
    .res    (step_res)
  );

  assign res_is_last = (res_idx_r == res_last_r);
  assign out_xfer = out_valid && out_ready;
  assign res_free = !res_vld_r || (out_ready && res_is_last);
  assign advance = in_vld_r && res_free;
  assign in_ready = !in_vld_r || advance;

  // input register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_vld_r <= 1'b0;
    end else if (in_ready) begin
      in_vld_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      in_item_r <= in_data;
    end
  end

  // port state: commit one update per advance
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= '0;
    end else if (advance) begin
      state_r <= state_nxt;
    end
  end

  // result buffer
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      res_vld_r <= 1'b0;
      res_idx_r <= '0;
      res_last_r <= '0;
    end else if (advance) begin
      res_vld_r <= 1'b1;
      res_idx_r <= '0;
      res_last_r <= EV_IDX_W'(step_res.count - (EV_IDX_W+1)'(1));
    end else if (out_xfer) begin
      if (res_is_last) begin
        res_vld_r <= 1'b0;
      end else begin
        res_idx_r <= res_idx_r + EV_IDX_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      res_ev_r <= step_res.ev;
      res_sol_r <= state_nxt.rewarding;
      res_las_r <= state_nxt.laser_lit;
      res_seen_r <= step_res.seen;
    end
  end

  assign out_valid = res_vld_r;
  assign out_data.event_res = res_ev_r[res_idx_r];
  assign out_data.solenoid = res_sol_r;
  assign out_data.laser = res_las_r;
  assign out_data.nose_in_seen = res_seen_r;
  assign out_data.last = res_is_last;

`ifndef NO_ASSERTIONS
  a_idx_bound: assert property (@(posedge clk) disable iff (!rst_n)
    res_vld_r |-> (res_idx_r <= res_last_r))
    else $error("result index beyond last record");

  a_in_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (in_vld_r && !advance) |=> (in_vld_r && $stable(in_item_r)))
    else $error("pending update lost while result buffer busy");

  a_none_alone: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && (out_data.event_res == EV_NONE)) |-> (out_data.last && (res_idx_r == '0)))
    else $error("empty event record not alone in its update");

  a_laser_stim: assert property (@(posedge clk) disable iff (!rst_n)
    state_r.laser_lit |-> state_r.stim_active)
    else $error("laser lit without an active stimulus");
`endif

endmodule
